// ----- sv/cfc_pkg.sv -----
// ----------------------------------------------------------------------------
// Chunk framer package
// Shared types, constants and the CRC-32 lookup table for the chunk framer.
// ----------------------------------------------------------------------------
package cfc_pkg;

	typedef struct packed {
		logic        mode;
		logic [7:0]  chunk_type;
		logic [7:0]  chunk_version;
		logic [31:0] payload_length;
		logic [7:0]  data_byte;
	} cfc_item_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic [1:0]  byte_kind;
		logic        last;
		logic        chunk_done;
		logic [47:0] chunk_offset;
		logic [32:0] chunk_total;
		logic        error;
	} cfc_result_t;

	typedef enum logic [1:0] {
		OP_BEGIN,
		OP_PAYLOAD,
		OP_STRAY
	} cfc_op_t;

	typedef struct packed {
		cfc_op_t     op;
		logic [7:0]  chunk_type;
		logic [7:0]  chunk_version;
		logic [31:0] payload_length;
		logic [7:0]  data_byte;
		logic [31:0] crc_out;
		logic        has_crc;
		logic        err;
		logic [47:0] offset;
		logic [32:0] total;
	} cfc_desc_t;

	localparam logic       MODE_BEGIN   = 1'b0;
	localparam logic [1:0] KIND_HEADER  = 2'd0;
	localparam logic [1:0] KIND_PAYLOAD = 2'd1;
	localparam logic [1:0] KIND_CRC     = 2'd2;
	localparam logic [1:0] KIND_NONE    = 2'd3;

	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

	localparam logic [3:0] IDX_ID          = 4'd0;
	localparam logic [3:0] IDX_VERSION     = 4'd1;
	localparam logic [3:0] IDX_LEN0        = 4'd2;
	localparam logic [3:0] IDX_LEN1        = 4'd3;
	localparam logic [3:0] IDX_LEN2        = 4'd4;
	localparam logic [3:0] IDX_LEN3        = 4'd5;
	localparam logic [3:0] IDX_HDR_LAST    = 4'd9;
	localparam logic [3:0] IDX_BEGIN_CRC   = 4'd10;
	localparam logic [3:0] IDX_BEGIN_LAST  = 4'd13;
	localparam logic [3:0] IDX_PAY_CRC     = 4'd1;
	localparam logic [3:0] IDX_PAY_LAST    = 4'd4;

	localparam logic [47:0] OFS_HEADER      = 48'd10;
	localparam logic [47:0] OFS_HEADER_CRC  = 48'd14;
	localparam logic [47:0] OFS_BYTE        = 48'd1;
	localparam logic [47:0] OFS_BYTE_CRC    = 48'd5;
	localparam logic [32:0] FRAME_OVERHEAD  = 33'd14;

	typedef logic [31:0] crc_table_t [256];

	function automatic crc_table_t crc_gen_table();
		crc_table_t tbl;
		logic [31:0] c;
		for (int i = 0; i < 256; i++) begin
			c = 32'(i);
			for (int j = 0; j < 8; j++) begin
				c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
			end
			tbl[i] = c;
		end
		return tbl;
	endfunction

	localparam crc_table_t CRC_TABLE = crc_gen_table();

endpackage

// ----- sv/cfc_core.sv -----
// ----------------------------------------------------------------------------
// Chunk framer state core
// Takes one item per cycle while not stalled, updates the chunk state and
// CRC, and hands a result descriptor to the emitter.
// ----------------------------------------------------------------------------
module cfc_core import cfc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_stall,
	input  cfc_item_t item,
	output logic      desc_valid,
	output cfc_desc_t desc,
	input  logic      desc_take
);

	logic [31:0] crc_q;
	logic [31:0] left_q;
	logic        open_q;
	logic [47:0] offset_q;
	logic [47:0] start_q;
	logic [32:0] total_q;
	logic        desc_valid_q;
	cfc_desc_t   desc_q;

	logic        accept;
	logic [7:0]  crc_idx;
	logic [31:0] crc_upd;
	logic [31:0] left_dec;
	logic        pay_done;
	logic        len_zero;
	logic [32:0] begin_total;

	assign item_stall  = desc_valid_q && !desc_take;
	assign accept      = item_valid && !item_stall;
	assign crc_idx     = crc_q[7:0] ^ item.data_byte;
	assign crc_upd     = CRC_TABLE[crc_idx] ^ {8'h00, crc_q[31:8]};
	assign left_dec    = left_q - 32'd1;
	assign pay_done    = (left_dec == 32'd0);
	assign len_zero    = (item.payload_length == 32'd0);
	assign begin_total = {1'b0, item.payload_length} + FRAME_OVERHEAD;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q        <= CRC_INIT;
			left_q       <= '0;
			open_q       <= 1'b0;
			offset_q     <= '0;
			start_q      <= '0;
			desc_valid_q <= 1'b0;
		end else if (accept) begin
			desc_valid_q <= 1'b1;
			if (item.mode == MODE_BEGIN) begin
				crc_q    <= CRC_INIT;
				left_q   <= item.payload_length;
				open_q   <= !len_zero;
				start_q  <= offset_q;
				offset_q <= offset_q + (len_zero ? OFS_HEADER_CRC : OFS_HEADER);
			end else if (open_q) begin
				crc_q    <= pay_done ? CRC_INIT : crc_upd;
				left_q   <= left_dec;
				open_q   <= !pay_done;
				offset_q <= offset_q + (pay_done ? OFS_BYTE_CRC : OFS_BYTE);
			end
		end else if (desc_take) begin
			desc_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && item.mode == MODE_BEGIN) begin
			total_q <= begin_total;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			desc_q.chunk_type     <= item.chunk_type;
			desc_q.chunk_version  <= item.chunk_version;
			desc_q.payload_length <= item.payload_length;
			desc_q.data_byte      <= item.data_byte;
			if (item.mode == MODE_BEGIN) begin
				desc_q.op      <= OP_BEGIN;
				desc_q.crc_out <= ~CRC_INIT;
				desc_q.has_crc <= len_zero;
				desc_q.err     <= open_q;
				desc_q.offset  <= offset_q;
				desc_q.total   <= begin_total;
			end else if (open_q) begin
				desc_q.op      <= OP_PAYLOAD;
				desc_q.crc_out <= ~crc_upd;
				desc_q.has_crc <= pay_done;
				desc_q.err     <= 1'b0;
				desc_q.offset  <= start_q;
				desc_q.total   <= total_q;
			end else begin
				desc_q.op      <= OP_STRAY;
				desc_q.crc_out <= '0;
				desc_q.has_crc <= 1'b0;
				desc_q.err     <= 1'b1;
				desc_q.offset  <= '0;
				desc_q.total   <= '0;
			end
		end
	end

	assign desc_valid = desc_valid_q;
	assign desc       = desc_q;

endmodule

// ----- sv/cfc_emit.sv -----
// ----------------------------------------------------------------------------
// Chunk framer emitter
// Steps through the results of one descriptor, one per cycle while the
// receiver does not stall, into a registered output stage.
// ----------------------------------------------------------------------------
module cfc_emit import cfc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        desc_valid,
	input  cfc_desc_t   desc,
	output logic        desc_take,
	output logic        result_valid,
	input  logic        result_stall,
	output cfc_result_t result
);

	logic [3:0]  idx_q;
	logic        out_valid_q;
	cfc_result_t out_q;

	logic        load;
	logic        is_last;
	logic [3:0]  last_idx;
	logic [3:0]  crc_sel;
	logic [7:0]  crc_byte;
	cfc_result_t res;

	always_comb begin
		case (desc.op)
			OP_BEGIN:   last_idx = desc.has_crc ? IDX_BEGIN_LAST : IDX_HDR_LAST;
			OP_PAYLOAD: last_idx = desc.has_crc ? IDX_PAY_LAST : IDX_ID;
			default:    last_idx = IDX_ID;
		endcase
	end

	assign is_last   = (idx_q == last_idx);
	assign load      = desc_valid && (!out_valid_q || !result_stall);
	assign desc_take = load && is_last;
	assign crc_sel   = idx_q - ((desc.op == OP_BEGIN) ? IDX_BEGIN_CRC : IDX_PAY_CRC);
	assign crc_byte  = desc.crc_out[{crc_sel[1:0], 3'b000} +: 8];

	always_comb begin
		res       = '0;
		res.error = desc.err;
		case (desc.op)
			OP_BEGIN: begin
				if (idx_q > IDX_HDR_LAST) begin
					res.byte_kind = KIND_CRC;
					res.out_byte  = crc_byte;
				end else begin
					res.byte_kind = KIND_HEADER;
					case (idx_q)
						IDX_ID:      res.out_byte = desc.chunk_type;
						IDX_VERSION: res.out_byte = desc.chunk_version;
						IDX_LEN0:    res.out_byte = desc.payload_length[7:0];
						IDX_LEN1:    res.out_byte = desc.payload_length[15:8];
						IDX_LEN2:    res.out_byte = desc.payload_length[23:16];
						IDX_LEN3:    res.out_byte = desc.payload_length[31:24];
						default:     res.out_byte = 8'h00;
					endcase
				end
			end
			OP_PAYLOAD: begin
				if (idx_q == IDX_ID) begin
					res.byte_kind = KIND_PAYLOAD;
					res.out_byte  = desc.data_byte;
				end else begin
					res.byte_kind = KIND_CRC;
					res.out_byte  = crc_byte;
				end
			end
			default: begin
				res.byte_kind = KIND_NONE;
				res.out_byte  = 8'h00;
			end
		endcase
		res.last = is_last;
		if (is_last && desc.has_crc) begin
			res.chunk_done   = 1'b1;
			res.chunk_offset = desc.offset;
			res.chunk_total  = desc.total;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (load) begin
			idx_q       <= is_last ? 4'd0 : idx_q + 4'd1;
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= res;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

// ----- sv/chunk_framer_crc32.sv -----
// ----------------------------------------------------------------------------
// Chunk framer with CRC-32
// Frames a byte stream into length-prefixed chunks, each closed by a CRC-32.
// ----------------------------------------------------------------------------
// The item channel takes begin transactions (chunk id, version, payload
// length) and payload byte transactions. The result channel delivers one
// stream byte per transaction, tagged as header, payload, CRC or no byte.
// A begin produces a 10-byte header, or 14 results for an empty chunk. A
// payload byte produces one result, or five when it is the last one of its
// chunk. A stray payload byte produces one flagged result with no byte.
// The first result of an item passes through the descriptor register and
// then the output register. Results flow at one per cycle while the
// receiver does not stall. State and CRC update in the accept cycle
// through one 256-entry table lookup.
// Reset closes any open chunk and clears the stream offset and both valid
// flags. While the receiver stalls, the output register holds its result,
// one pending item descriptor is kept, and the item channel stalls.
// ----------------------------------------------------------------------------
module chunk_framer_crc32 import cfc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  cfc_item_t   item,
	output logic        result_valid,
	input  logic        result_stall,
	output cfc_result_t result
);

	logic      desc_valid;
	logic      desc_take;
	cfc_desc_t desc;

	cfc_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.desc_valid (desc_valid),
		.desc       (desc),
		.desc_take  (desc_take)
	);

	cfc_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.desc_valid   (desc_valid),
		.desc         (desc),
		.desc_take    (desc_take),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// Chunk framer testbench
// Drives begin, payload and stray byte transactions into the chunk framer and
// compares every result transaction with a cycle-free model of the framing,
// the CRC-32 and the chunk index fields, under random idling on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import cfc_pkg::*;

	localparam logic MODE_DATA = 1'b1;
	localparam int IDLE_PERCENT = 6;
	localparam int DRAIN_CYCLES = 20;
	localparam int RANDOM_ITEMS = 400;
	localparam int PRINT_LIMIT = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	cfc_item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	cfc_result_t result;

	bit idle_off = 1'b0;
	int error_count = 0;
	cfc_result_t expected_bytes[$];

	logic [31:0] crc_state = CRC_INIT;
	logic [31:0] payload_left = '0;
	bit chunk_is_open = 1'b0;
	logic [47:0] stream_pos = '0;
	logic [47:0] chunk_start = '0;

	chunk_framer_crc32 dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always #1 clk = ~clk;

	task automatic report_error(input string msg);
		error_count++;
		if (error_count <= PRINT_LIMIT) begin
			$display("ERROR at %0t: %s", $realtime, msg);
		end
	endtask

	function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

	task automatic queue_byte(input logic [7:0] b, input logic [1:0] kind, input logic err);
		cfc_result_t r;
		r = '0;
		r.out_byte = b;
		r.byte_kind = kind;
		r.error = err;
		expected_bytes = {expected_bytes, r};
		if (kind != KIND_NONE) begin
			stream_pos = stream_pos + 48'd1;
		end
	endtask

	task automatic queue_crc(input logic err);
		logic [31:0] c;
		cfc_result_t r;
		c = ~crc_state;
		for (int i = 0; i < 4; i++) begin
			queue_byte(c[8*i +: 8], KIND_CRC, err);
		end
		r = expected_bytes.pop_back();
		r.chunk_done = 1'b1;
		r.chunk_offset = chunk_start;
		r.chunk_total = 33'(stream_pos - chunk_start);
		expected_bytes = {expected_bytes, r};
		chunk_is_open = 1'b0;
		crc_state = CRC_INIT;
	endtask

	task automatic predict_item(input cfc_item_t it);
		logic err;
		cfc_result_t r;
		if (it.mode == MODE_BEGIN) begin
			err = chunk_is_open;
			chunk_start = stream_pos;
			crc_state = CRC_INIT;
			queue_byte(it.chunk_type, KIND_HEADER, err);
			queue_byte(it.chunk_version, KIND_HEADER, err);
			for (int i = 0; i < 8; i++) begin
				queue_byte(i < 4 ? it.payload_length[8*i +: 8] : 8'h00, KIND_HEADER, err);
			end
			payload_left = it.payload_length;
			chunk_is_open = 1'b1;
			if (it.payload_length == 32'd0) begin
				queue_crc(err);
			end
		end else if (!chunk_is_open) begin
			queue_byte(8'h00, KIND_NONE, 1'b1);
		end else begin
			queue_byte(it.data_byte, KIND_PAYLOAD, 1'b0);
			crc_state = crc_byte(crc_state, it.data_byte);
			payload_left = payload_left - 32'd1;
			if (payload_left == 32'd0) begin
				queue_crc(1'b0);
			end
		end
		r = expected_bytes.pop_back();
		r.last = 1'b1;
		expected_bytes = {expected_bytes, r};
	endtask

	task automatic check_result(input cfc_result_t got);
		cfc_result_t exp;
		if (expected_bytes.size() == 0) begin
			report_error($sformatf("unexpected result %h", got));
		end else begin
			exp = expected_bytes.pop_front();
			if (got.out_byte !== exp.out_byte)
				report_error($sformatf("out_byte %h, expected %h", got.out_byte, exp.out_byte));
			if (got.byte_kind !== exp.byte_kind)
				report_error($sformatf("byte_kind %h, expected %h", got.byte_kind, exp.byte_kind));
			if (got.last !== exp.last)
				report_error($sformatf("last %b, expected %b", got.last, exp.last));
			if (got.chunk_done !== exp.chunk_done)
				report_error($sformatf("chunk_done %b, expected %b",
					got.chunk_done, exp.chunk_done));
			if (got.chunk_offset !== exp.chunk_offset)
				report_error($sformatf("chunk_offset %h, expected %h",
					got.chunk_offset, exp.chunk_offset));
			if (got.chunk_total !== exp.chunk_total)
				report_error($sformatf("chunk_total %h, expected %h",
					got.chunk_total, exp.chunk_total));
			if (got.error !== exp.error)
				report_error($sformatf("error %b, expected %b", got.error, exp.error));
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid === 1'b1 && !result_stall) begin
				check_result(result);
			end
			result_stall <= !idle_off && ($urandom_range(99) < IDLE_PERCENT);
		end
	end

	task automatic send_item(input cfc_item_t it);
		while (!idle_off && $urandom_range(99) < IDLE_PERCENT) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		predict_item(it);
		@(posedge clk);
		while (item_stall !== 1'b0) begin
			@(posedge clk);
		end
	endtask

	function automatic cfc_item_t chunk_begin_item(input logic [7:0] id, input logic [7:0] ver,
			input logic [31:0] len);
		cfc_item_t it;
		it.mode = MODE_BEGIN;
		it.chunk_type = id;
		it.chunk_version = ver;
		it.payload_length = len;
		it.data_byte = 8'($urandom);
		return it;
	endfunction

	function automatic cfc_item_t data_item(input logic [7:0] b);
		cfc_item_t it;
		it.mode = MODE_DATA;
		it.chunk_type = 8'($urandom);
		it.chunk_version = 8'($urandom);
		it.payload_length = $urandom;
		it.data_byte = b;
		return it;
	endfunction

	task automatic test_stray_bytes();
		send_item(data_item(8'h00));
		send_item(data_item(8'hFF));
	endtask

	task automatic test_empty_chunks();
		send_item(chunk_begin_item(8'hFF, 8'h00, 32'd0));
		send_item(chunk_begin_item(8'h00, 8'hFF, 32'd0));
	endtask

	task automatic test_short_chunk();
		send_item(chunk_begin_item(8'h5A, 8'hA5, 32'd4));
		send_item(data_item(8'h00));
		send_item(data_item(8'hFF));
		send_item(data_item(8'h80));
		send_item(data_item(8'h01));
	endtask

	// A begin that arrives while a chunk is open abandons it without a CRC.
	task automatic test_abandoned_chunks();
		send_item(chunk_begin_item(8'h12, 8'h34, 32'hFFFF_FFFF));
		send_item(data_item(8'h3C));
		send_item(chunk_begin_item(8'hC3, 8'h01, 32'h8000_0001));
		send_item(data_item(8'hAA));
		send_item(chunk_begin_item(8'h7E, 8'hE7, 32'd1));
		send_item(data_item(8'hFF));
		send_item(data_item(8'h55));
	endtask

	// Mostly complete chunks with random content, mixed with abandoned chunks,
	// stray bytes and fully random transactions.
	task automatic test_random_stream();
		int sent;
		int pick;
		int len;
		int lim;
		int n;
		logic [31:0] long_len;
		logic [63:0] raw;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			idle_off = (sent >= 150 && sent < 250);
			pick = $urandom_range(99);
			if (pick < 70) begin
				len = ($urandom_range(19) == 0) ? $urandom_range(200, 60) : $urandom_range(24);
				send_item(chunk_begin_item(8'($urandom), 8'($urandom), 32'(len)));
				sent++;
				for (n = 0; n < len; n++) begin
					send_item(data_item(8'($urandom)));
					sent++;
				end
			end else if (pick < 80) begin
				long_len = $urandom_range(1) ? $urandom : 32'($urandom_range(40, 2));
				if (long_len < 32'd2) begin
					long_len = 32'd2;
				end
				lim = (long_len > 32'd8) ? 8 : int'(long_len) - 1;
				send_item(chunk_begin_item(8'($urandom), 8'($urandom), long_len));
				sent++;
				for (n = $urandom_range(lim); n > 0; n--) begin
					send_item(data_item(8'($urandom)));
					sent++;
				end
			end else if (pick < 90) begin
				for (n = $urandom_range(3, 1); n > 0; n--) begin
					send_item(data_item(8'($urandom)));
					sent++;
				end
			end else begin
				raw = {$urandom, $urandom};
				send_item(raw[$bits(cfc_item_t)-1:0]);
				sent++;
			end
		end
		idle_off = 1'b0;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		test_stray_bytes();
		test_empty_chunks();
		test_short_chunk();
		test_abandoned_chunks();
		test_random_stream();
		item_valid <= 1'b0;
		while (expected_bytes.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin
		#1000000;
		$display("Timeout with %0d results outstanding", expected_bytes.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
